/* rtl/scan_disk_scheduler_defines.svh */
// Assertion macros for the SCAN disk scheduler.
// Included by the top level; needs clk and rst_n in the including scope.
`ifndef SCAN_DISK_SCHEDULER_DEFINES_SVH
`define SCAN_DISK_SCHEDULER_DEFINES_SVH

`ifndef SYNTHESIS

// Check that a condition implies a same-cycle consequence
`define SDS_ASSERT_NOW(label, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error("scheduler check failed");

// Check that a condition implies a consequence in the next cycle
`define SDS_ASSERT_NEXT(label, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("scheduler check failed");

`else

`define SDS_ASSERT_NOW(label, cond, conseq)
`define SDS_ASSERT_NEXT(label, cond, conseq)

`endif

`endif

/* rtl/sds_pkg.sv */
// Shared constants, types and the sweep ordering key for the SCAN scheduler.
// No dependencies; used by sds_req_store and scan_disk_scheduler.
package sds_pkg;

    localparam int MAX_REQUESTS = 16;
    localparam int CYL_W        = 16;
    localparam int SEEK_W       = 18;
    localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
    localparam int ADDR_W       = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int SEL_W        = $clog2(MAX_REQUESTS + 1);
    localparam int REM_W        = $clog2(MAX_REQUESTS + 2);
    localparam int KEY_W        = CYL_W + 1;

    localparam logic [CYL_W-1:0]  MAX_CYL_RESET = CYL_W'(200);
    localparam logic [CYL_W-1:0]  CYL_BOTTOM    = '0;
    localparam logic [SEEK_W-1:0] SEEK_MAX      = {SEEK_W{1'b1}};

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_RUN  = 1'b1;
    localparam logic DIR_DOWN = 1'b0;

    typedef struct packed {
        logic load;
        logic clear;
    } store_cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             dropped;
    } store_status_t;

    // Ordering key: smaller key is visited earlier in the sweep
    function automatic logic [KEY_W-1:0] sweep_key(
        input logic [CYL_W-1:0] cyl,
        input logic             is_lower,
        input logic             down
    );
        logic [KEY_W-1:0] key;
        if (down)
        begin
            key = is_lower ? {1'b0, ~cyl} : {1'b1, cyl};
        end
        else
        begin
            key = is_lower ? {1'b1, ~cyl} : {1'b0, cyl};
        end
        return key;
    endfunction

endpackage

/* rtl/scan_disk_scheduler.sv */
// SCAN disk scheduler. A run over n stored requests gives n+1 results, each
// found by one compare per element on the shared selection unit and then
// written out by a seek-update step.
// A result shows for one cycle on result_valid; the receiver cannot stall.
// Reset empties the store, clears the drop flag and sets max_cylinder to 200.
// Depends on sds_pkg, sds_req_store and scan_disk_scheduler_defines.svh.
`include "scan_disk_scheduler_defines.svh"

module scan_disk_scheduler (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        command,
    input  logic [sds_pkg::CYL_W-1:0]   request_cylinder,
    input  logic [sds_pkg::CYL_W-1:0]   start_head,
    input  logic                        direction,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [sds_pkg::CYL_W-1:0]   cfg_data,
    output logic                        result_valid,
    output logic [sds_pkg::CYL_W-1:0]   served_cylinder,
    output logic [sds_pkg::SEEK_W-1:0]  seek_total,
    output logic                        last_visit,
    output logic                        overflow
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]                     state_reg, state_next;
    logic [sds_pkg::CYL_W-1:0]      max_cyl_reg, max_cyl_next;
    logic [sds_pkg::CNT_W-1:0]      idx_reg, idx_next;
    logic [sds_pkg::REM_W-1:0]      remain_reg, remain_next;
    logic [sds_pkg::MAX_REQUESTS:0] used_reg, used_next;
    logic                           found_reg, found_next;
    logic                           result_valid_reg, result_valid_next;

    logic [sds_pkg::CYL_W-1:0]      head_reg, head_next;
    logic                           down_reg, down_next;
    logic [sds_pkg::KEY_W-1:0]      best_key_reg, best_key_next;
    logic [sds_pkg::CYL_W-1:0]      best_cyl_reg, best_cyl_next;
    logic [sds_pkg::SEL_W-1:0]      best_sel_reg, best_sel_next;
    logic [sds_pkg::CYL_W-1:0]      pos_reg, pos_next;
    logic [sds_pkg::SEEK_W-1:0]     seek_reg, seek_next;
    logic [sds_pkg::CYL_W-1:0]      out_cyl_reg, out_cyl_next;
    logic [sds_pkg::SEEK_W-1:0]     out_seek_reg, out_seek_next;
    logic                           out_last_reg, out_last_next;
    logic                           out_ovf_reg, out_ovf_next;

    sds_pkg::store_cmd_t            store_cmd;
    sds_pkg::store_status_t         store_status;
    logic [sds_pkg::CYL_W-1:0]      rd_cyl;

    logic                           accept;
    logic                           at_end;
    logic [sds_pkg::CYL_W-1:0]      elem_cyl;
    logic                           elem_lower;
    logic [sds_pkg::SEL_W-1:0]      elem_sel;
    logic [sds_pkg::KEY_W-1:0]      elem_key;
    logic                           take;
    logic [sds_pkg::CYL_W-1:0]      step_dist;
    logic [sds_pkg::SEEK_W:0]       seek_sum;
    logic                           is_last;

    // Address the store with the next scan index so read data lines up with idx_reg
    sds_req_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (store_cmd),
        .wr_cyl  (request_cylinder),
        .rd_addr (idx_next[sds_pkg::ADDR_W-1:0]),
        .rd_cyl  (rd_cyl),
        .status  (store_status)
    );

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign accept    = start && !busy;

    // Current scan element: stored requests first, then the disk end
    assign at_end     = (idx_reg == store_status.count);
    assign elem_cyl   = at_end ? (down_reg ? sds_pkg::CYL_BOTTOM : max_cyl_reg) : rd_cyl;
    assign elem_lower = at_end ? down_reg : (rd_cyl < head_reg);
    assign elem_sel   = at_end ? sds_pkg::SEL_W'(sds_pkg::MAX_REQUESTS) : idx_reg;
    assign elem_key   = sds_pkg::sweep_key(elem_cyl, elem_lower, down_reg);
    assign take       = !used_reg[elem_sel] && (!found_reg || (elem_key < best_key_reg));

    // Seek distance and saturating accumulation
    assign step_dist = (best_cyl_reg > pos_reg) ? (best_cyl_reg - pos_reg)
                                                : (pos_reg - best_cyl_reg);
    assign seek_sum  = {1'b0, seek_reg} + (sds_pkg::SEEK_W + 1)'(step_dist);
    assign is_last   = (remain_reg == sds_pkg::REM_W'(1));

    // Sequencer: scan all elements for the next in sweep order, then emit it
    always_comb
    begin
        state_next        = state_reg;
        max_cyl_next      = max_cyl_reg;
        idx_next          = idx_reg;
        remain_next       = remain_reg;
        used_next         = used_reg;
        found_next        = found_reg;
        result_valid_next = 1'b0;
        head_next         = head_reg;
        down_next         = down_reg;
        best_key_next     = best_key_reg;
        best_cyl_next     = best_cyl_reg;
        best_sel_next     = best_sel_reg;
        pos_next          = pos_reg;
        seek_next         = seek_reg;
        out_cyl_next      = out_cyl_reg;
        out_seek_next     = out_seek_reg;
        out_last_next     = out_last_reg;
        out_ovf_next      = out_ovf_reg;
        store_cmd.load    = 1'b0;
        store_cmd.clear   = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            max_cyl_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (command == sds_pkg::CMD_RUN)
                    begin
                        head_next   = start_head;
                        pos_next    = start_head;
                        down_next   = (direction == sds_pkg::DIR_DOWN);
                        seek_next   = '0;
                        used_next   = '0;
                        idx_next    = '0;
                        found_next  = 1'b0;
                        remain_next = sds_pkg::REM_W'(store_status.count) + 1'b1;
                        state_next  = ST_SCAN;
                    end
                    else
                    begin
                        store_cmd.load = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                if (take)
                begin
                    best_key_next = elem_key;
                    best_cyl_next = elem_cyl;
                    best_sel_next = elem_sel;
                    found_next    = 1'b1;
                end
                if (at_end)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                used_next[best_sel_reg] = 1'b1;
                seek_next         = seek_sum[sds_pkg::SEEK_W] ? sds_pkg::SEEK_MAX
                                                              : seek_sum[sds_pkg::SEEK_W-1:0];
                pos_next          = best_cyl_reg;
                out_cyl_next      = best_cyl_reg;
                out_seek_next     = seek_next;
                out_last_next     = is_last;
                out_ovf_next      = store_status.dropped;
                result_valid_next = 1'b1;
                remain_next       = remain_reg - 1'b1;
                idx_next          = '0;
                found_next        = 1'b0;
                if (is_last)
                begin
                    store_cmd.clear = 1'b1;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            max_cyl_reg      <= sds_pkg::MAX_CYL_RESET;
            idx_reg          <= '0;
            remain_reg       <= '0;
            used_reg         <= '0;
            found_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            max_cyl_reg      <= max_cyl_next;
            idx_reg          <= idx_next;
            remain_reg       <= remain_next;
            used_reg         <= used_next;
            found_reg        <= found_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        head_reg     <= head_next;
        down_reg     <= down_next;
        best_key_reg <= best_key_next;
        best_cyl_reg <= best_cyl_next;
        best_sel_reg <= best_sel_next;
        pos_reg      <= pos_next;
        seek_reg     <= seek_next;
        out_cyl_reg  <= out_cyl_next;
        out_seek_reg <= out_seek_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign result_valid    = result_valid_reg;
    assign served_cylinder = out_cyl_reg;
    assign seek_total      = out_seek_reg;
    assign last_visit      = out_last_reg;
    assign overflow        = out_ovf_reg;

    // Results come only out of the emit step
    `SDS_ASSERT_NOW(a_result_from_emit, result_valid, $past(state_reg == ST_EMIT))
    // A run command starts a scan
    `SDS_ASSERT_NEXT(a_run_starts_scan, accept && (command == sds_pkg::CMD_RUN), state_reg == ST_SCAN)
    // The final visit leaves the block idle with an empty store
    `SDS_ASSERT_NOW(a_last_empties, result_valid && last_visit, !busy && (store_status == '0))
    // A scan never walks past the fill count
    `SDS_ASSERT_NOW(a_scan_in_range, state_reg == ST_SCAN, idx_reg <= store_status.count)

endmodule

/* rtl/sds_req_store.sv */
// Pending request store: small register file plus fill count and drop flag.
// Depends on sds_pkg for widths and the command/status structs.
module sds_req_store (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sds_pkg::store_cmd_t         cmd,
    input  logic [sds_pkg::CYL_W-1:0]   wr_cyl,
    input  logic [sds_pkg::ADDR_W-1:0]  rd_addr,
    output logic [sds_pkg::CYL_W-1:0]   rd_cyl,
    output sds_pkg::store_status_t      status
);

    logic [sds_pkg::CYL_W-1:0] mem [sds_pkg::MAX_REQUESTS];
    logic [sds_pkg::CNT_W-1:0] count_reg;
    logic [sds_pkg::CNT_W-1:0] count_next;
    logic                      dropped_reg;
    logic                      dropped_next;
    logic                      full;

    assign full = (count_reg == sds_pkg::CNT_W'(sds_pkg::MAX_REQUESTS));

    // Advance fill count, flag drops on a full store, empty after a run
    always_comb
    begin
        count_next   = count_reg;
        dropped_next = dropped_reg;
        if (cmd.clear)
        begin
            count_next   = '0;
            dropped_next = 1'b0;
        end
        else if (cmd.load)
        begin
            if (full)
            begin
                dropped_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
        end
    end

    // Write the next free entry
    always_ff @(posedge clk)
    begin
        if (cmd.load && !cmd.clear && !full)
        begin
            mem[count_reg[sds_pkg::ADDR_W-1:0]] <= wr_cyl;
        end
    end

    // Register the addressed entry; data shows in the cycle after the address
    always_ff @(posedge clk)
    begin
        rd_cyl <= mem[rd_addr];
    end

    assign status.count   = count_reg;
    assign status.dropped = dropped_reg;

endmodule
